>>> rtl/core/ppt_pkg.sv
// Shared types, constants and helpers for the point-in-polygon ray casting block.
package ppt_pkg;

  // Fixed field widths
  localparam int COORD_BITS       = 16;
  localparam int DIFF_BITS        = COORD_BITS + 1;
  localparam int INDEX_BITS       = 4;
  localparam int VCOUNT_BITS      = 5;
  localparam int COUNT_OUT_BITS   = 5;
  localparam int MIN_VERTICES     = 3;
  localparam int MAX_VERTICES_DEF = 16;

  // Opcodes of an input transaction
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TEST = 1'b1;

  typedef struct packed {
    logic                         op;
    logic [INDEX_BITS-1:0]        vertex_index;
    logic signed [COORD_BITS-1:0] coord_x;
    logic signed [COORD_BITS-1:0] coord_y;
  } in_item_t;

  typedef struct packed {
    logic                      inside_res;
    logic [COUNT_OUT_BITS-1:0] crossing_count;
  } out_item_t;

  typedef enum logic {
    KIND_LOAD,
    KIND_QUERY
  } kind_t;

  typedef struct packed {
    kind_t                        kind;
    logic [INDEX_BITS-1:0]        vertex_index;
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
  } queue_item_t;

  typedef enum logic [1:0] {
    ORI_ZERO,
    ORI_POS,
    ORI_NEG
  } orient_t;

  typedef struct packed {
    logic valid;
    logic last;
  } edge_ctl_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_WALK,
    BK_DRAIN
  } back_state_t;

  // Orientation code from the sign of a difference
  function automatic orient_t orient_of(input logic signed [DIFF_BITS-1:0] v);
    orient_t o;
    priority if (v == '0) begin
      o = ORI_ZERO;
    end else if (v[DIFF_BITS-1]) begin
      o = ORI_NEG;
    end else begin
      o = ORI_POS;
    end
    return o;
  endfunction

  // Horizontal edge: sign of dx * (by - py), with pyb = py - by
  function automatic orient_t orient_hz(input logic signed [DIFF_BITS-1:0] dx,
                                        input logic signed [DIFF_BITS-1:0] pyb);
    orient_t o;
    priority if (dx == '0 || pyb == '0) begin
      o = ORI_ZERO;
    end else if (dx[DIFF_BITS-1] ^ pyb[DIFF_BITS-1]) begin
      o = ORI_POS;
    end else begin
      o = ORI_NEG;
    end
    return o;
  endfunction

endpackage

>>> rtl/core/ppt_front.sv
// Front end: accepts transactions, classifies them and queues them for the back end.
module ppt_front #(
  parameter int MAX_VERTICES = ppt_pkg::MAX_VERTICES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  ppt_pkg::in_item_t    item,
  input  logic                 pop,
  output logic                 busy,
  output logic                 q_valid,
  output ppt_pkg::queue_item_t q_item
);

  ppt_pkg::queue_item_t q_mem [2];
  logic                 wr_ptr;
  logic                 rd_ptr;
  logic [1:0]           q_count;
  logic                 keep;
  logic                 push;
  logic                 do_pop;
  ppt_pkg::queue_item_t cls;

  // Loads to slots beyond the store are dropped here
  assign keep = (item.op == ppt_pkg::OP_TEST) || (int'(item.vertex_index) < MAX_VERTICES);

  always_comb begin
    cls.kind         = (item.op == ppt_pkg::OP_TEST) ? ppt_pkg::KIND_QUERY : ppt_pkg::KIND_LOAD;
    cls.vertex_index = item.vertex_index;
    cls.x            = item.coord_x;
    cls.y            = item.coord_y;
  end

  assign busy    = (q_count == 2'd2);
  assign push    = start && !busy && keep;
  assign q_valid = (q_count != 2'd0);
  assign do_pop  = pop && q_valid;
  assign q_item  = q_mem[rd_ptr];

  // Queue payload
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= cls;
    end
  end

  // Queue pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= 1'b0;
      rd_ptr  <= 1'b0;
      q_count <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      q_count <= q_count + 2'(push) - 2'(do_pop);
    end
  end

endmodule

>>> rtl/core/ppt_edge.sv
// Edge test pipeline: one polygon edge per cycle, crossing flag registered through stages 2 and 3.
module ppt_edge (
  input  logic                                  clk,
  input  logic                                  rst,
  input  ppt_pkg::edge_ctl_t                    ctl_in,
  input  logic signed [ppt_pkg::COORD_BITS-1:0] px,
  input  logic signed [ppt_pkg::COORD_BITS-1:0] py,
  input  logic signed [ppt_pkg::COORD_BITS-1:0] ax,
  input  logic signed [ppt_pkg::COORD_BITS-1:0] ay,
  input  logic signed [ppt_pkg::COORD_BITS-1:0] bx,
  input  logic signed [ppt_pkg::COORD_BITS-1:0] by,
  output ppt_pkg::edge_ctl_t                    ctl_out,
  output logic                                  crossed
);

  localparam int D = ppt_pkg::DIFF_BITS;

  logic signed [D-1:0]   dx, dy, pxb, pyb, pya;
  ppt_pkg::edge_ctl_t    s2_ctl, s3_ctl;
  logic signed [D-1:0]   s2_dx, s2_dy, s2_pxb, s2_pyb;
  ppt_pkg::orient_t      s2_o1, s2_o2, s2_o4;
  logic signed [2*D-1:0] s3_p1, s3_p2;
  ppt_pkg::orient_t      s3_o1, s3_o2, s3_o4, o3;

  // Differences
  assign dx  = D'(bx) - D'(ax);
  assign dy  = D'(by) - D'(ay);
  assign pxb = D'(px) - D'(bx);
  assign pyb = D'(py) - D'(by);
  assign pya = D'(py) - D'(ay);

  // Stage 2: differences and the three cheap orientations
  always_ff @(posedge clk) begin
    s2_dx  <= dx;
    s2_dy  <= dy;
    s2_pxb <= pxb;
    s2_pyb <= pyb;
    s2_o1  <= ppt_pkg::orient_of(pya);
    s2_o2  <= ppt_pkg::orient_of(pyb);
    s2_o4  <= (dy != '0) ? ppt_pkg::orient_of(dy) : ppt_pkg::orient_hz(dx, pyb);
  end

  // Stage 3: cross product terms
  always_ff @(posedge clk) begin
    s3_p1 <= s2_dy * s2_pxb;
    s3_p2 <= s2_dx * s2_pyb;
    s3_o1 <= s2_o1;
    s3_o2 <= s2_o2;
    s3_o4 <= s2_o4;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_ctl <= '0;
      s3_ctl <= '0;
    end else begin
      s2_ctl <= ctl_in;
      s3_ctl <= s2_ctl;
    end
  end

  // Orientation of the point against the edge, then the crossing rule
  always_comb begin
    priority if (s3_p1 > s3_p2) begin
      o3 = ppt_pkg::ORI_POS;
    end else if (s3_p1 < s3_p2) begin
      o3 = ppt_pkg::ORI_NEG;
    end else begin
      o3 = ppt_pkg::ORI_ZERO;
    end
  end

  assign crossed = (s3_o1 != s3_o2) && (o3 != s3_o4);
  assign ctl_out = s3_ctl;

endmodule

>>> rtl/core/ppt_back.sv
// Back end: vertex store, edge walk sequencer and crossing counter.
module ppt_back #(
  parameter int MAX_VERTICES = ppt_pkg::MAX_VERTICES_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               q_valid,
  input  ppt_pkg::queue_item_t               q_item,
  input  logic [ppt_pkg::VCOUNT_BITS-1:0]    vertex_count,
  output logic                               pop,
  output logic                               done,
  output ppt_pkg::out_item_t                 result
);

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int NW = $clog2(MAX_VERTICES + 1);
  localparam int C  = ppt_pkg::COORD_BITS;

  logic signed [C-1:0]  mem_x [MAX_VERTICES];
  logic signed [C-1:0]  mem_y [MAX_VERTICES];

  ppt_pkg::back_state_t state, state_next;
  logic [NW-1:0]        k, n, n_sat, count, count_total;
  logic signed [C-1:0]  px, py, ax, ay, rx, ry;
  logic                 s1_valid, s1_first, s1_last;
  logic                 issue, begin_walk, short_emit, mem_we;
  logic [AW-1:0]        rd_addr;
  ppt_pkg::edge_ctl_t   e_in, e_out;
  logic                 crossed;

  // Vertex count clipped to the store size
  assign n_sat = (int'(vertex_count) > MAX_VERTICES) ? NW'(MAX_VERTICES) : NW'(vertex_count);

  // Sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ppt_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    issue      = 1'b0;
    begin_walk = 1'b0;
    short_emit = 1'b0;
    mem_we     = 1'b0;
    unique case (state)
      ppt_pkg::BK_IDLE: begin
        if (q_valid) begin
          pop = 1'b1;
          if (q_item.kind == ppt_pkg::KIND_QUERY) begin
            if (int'(n_sat) < ppt_pkg::MIN_VERTICES) begin
              short_emit = 1'b1;
            end else begin
              begin_walk = 1'b1;
              state_next = ppt_pkg::BK_WALK;
            end
          end else begin
            mem_we = 1'b1;
          end
        end
      end
      ppt_pkg::BK_WALK: begin
        issue = 1'b1;
        if (k == n) begin
          state_next = ppt_pkg::BK_DRAIN;
        end
      end
      ppt_pkg::BK_DRAIN: begin
        if (e_out.valid && e_out.last) begin
          state_next = ppt_pkg::BK_IDLE;
        end
      end
      default: begin
        state_next = ppt_pkg::BK_IDLE;
      end
    endcase
  end

  // Vertex store; the closing edge reads vertex 0 again
  assign rd_addr = (k == n) ? '0 : k[AW-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_x[AW'(q_item.vertex_index)] <= q_item.x;
      mem_y[AW'(q_item.vertex_index)] <= q_item.y;
    end
    rx <= mem_x[rd_addr];
    ry <= mem_y[rd_addr];
  end

  // Query point, walk counter and previous vertex
  always_ff @(posedge clk) begin
    if (begin_walk) begin
      px <= q_item.x;
      py <= q_item.y;
      n  <= n_sat;
      k  <= '0;
    end else if (issue) begin
      k <= k + NW'(1);
    end
    if (s1_valid) begin
      ax <= rx;
      ay <= ry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_first <= 1'b0;
      s1_last  <= 1'b0;
    end else begin
      s1_valid <= issue;
      s1_first <= issue && (k == '0);
      s1_last  <= issue && (k == n);
    end
  end

  // First vertex read only primes the previous-vertex register
  assign e_in.valid = s1_valid && !s1_first;
  assign e_in.last  = s1_last;

  ppt_edge u_edge (
    .clk     (clk),
    .rst     (rst),
    .ctl_in  (e_in),
    .px      (px),
    .py      (py),
    .ax      (ax),
    .ay      (ay),
    .bx      (rx),
    .by      (ry),
    .ctl_out (e_out),
    .crossed (crossed)
  );

  // Crossing counter
  assign count_total = count + NW'(e_out.valid && crossed);

  always_ff @(posedge clk) begin
    if (begin_walk) begin
      count <= '0;
    end else if (e_out.valid) begin
      count <= count_total;
    end
  end

  // Result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= short_emit || (e_out.valid && e_out.last);
    end
  end

  always_ff @(posedge clk) begin
    if (short_emit) begin
      result <= '0;
    end else if (e_out.valid && e_out.last) begin
      result.inside_res     <= count_total[0];
      result.crossing_count <= ppt_pkg::COUNT_OUT_BITS'(count_total);
    end
  end

endmodule

>>> rtl/core/point_in_polygon_test_top.sv
// Top level of the point-in-polygon ray casting block.
// A query with n >= 3 vertices walks the edges before done; below that it is answered with a zero result.
// Throughput: a query walks one edge per cycle through the single store read port,
// and the back end takes no new item until the query has drained; a vertex load is written as it is popped.
// A two-entry queue lets start be taken while a query runs; results are never held off.
// Synchronous reset clears vertex_count, the queue and all control; the store is not cleared.
module point_in_polygon_test_top #(
  parameter int MAX_VERTICES = ppt_pkg::MAX_VERTICES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  ppt_pkg::in_item_t               item,
  input  logic                            cfg_we,
  input  logic [ppt_pkg::VCOUNT_BITS-1:0] cfg_data,
  output logic                            done,
  output ppt_pkg::out_item_t              result
);

  logic [ppt_pkg::VCOUNT_BITS-1:0] vertex_count;
  logic                            q_valid;
  logic                            pop;
  ppt_pkg::queue_item_t            q_item;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= '0;
    end else if (cfg_we) begin
      vertex_count <= cfg_data;
    end
  end

  ppt_front #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .item    (item),
    .pop     (pop),
    .busy    (busy),
    .q_valid (q_valid),
    .q_item  (q_item)
  );

  ppt_back #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .vertex_count (vertex_count),
    .pop          (pop),
    .done         (done),
    .result       (result)
  );

endmodule
